FILE: sv/ase_pkg.sv
// Shared types, constants and helpers of the approximate substring matcher.
package ase_pkg;

    localparam int ASE_QUERY_MAX = 64;
    localparam int ASE_TEXT_MAX  = 4096;

    localparam int CH_W   = 8;
    localparam int MAXD_W = 7;
    localparam int DIST_W = 13;

    localparam logic [MAXD_W-1:0] MAXD_RESET = 7'd2;

    localparam logic MODE_QUERY = 1'b0;
    localparam logic MODE_TEXT  = 1'b1;

    // control that travels with each text character down the cell row
    typedef struct packed {
        logic            valid;
        logic            proc;   // character is within the text capacity
        logic            last;   // final character of the text
        logic [CH_W-1:0] ch;     // case-folded character
    } t_tok;

    // query load and column clear, broadcast to every cell
    typedef struct packed {
        logic            we;
        logic            clr;
        logic [CH_W-1:0] ch;
    } t_ld;

    function automatic logic [CH_W-1:0] fold_case(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

FILE: sv/ase_cell.sv
// One query cell: holds a query character and its distance row entry.
module ase_cell #(
    parameter int QUERY_MAX = ase_pkg::ASE_QUERY_MAX,
    parameter int INDEX     = 1,
    localparam int LW       = $clog2(QUERY_MAX + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_stall,
    input  ase_pkg::t_ld    i_ld,
    input  logic [LW-1:0]   i_ld_idx,
    input  logic [LW-1:0]   i_qlen,
    input  ase_pkg::t_tok   i_tok,
    input  logic [LW-1:0]   i_up,
    input  logic [LW-1:0]   i_diag,
    input  logic [LW-1:0]   i_row,
    output ase_pkg::t_tok   o_tok,
    output logic [LW-1:0]   o_up,
    output logic [LW-1:0]   o_diag,
    output logic [LW-1:0]   o_row
);
    import ase_pkg::*;

    localparam logic [LW-1:0] IDX    = LW'(INDEX);
    localparam logic [LW-1:0] IDX_M1 = LW'(INDEX - 1);

    logic [CH_W-1:0] r_q;
    logic [LW-1:0]   r_d, n_d;
    t_tok            r_tok;
    logic [LW-1:0]   r_up, r_diag, r_row;
    logic [LW-1:0]   w_min, w_v;

    always_comb begin
        w_min = (i_up < r_d) ? i_up : r_d;
        w_min = (i_diag < w_min) ? i_diag : w_min;
        w_v   = (r_q == i_tok.ch) ? i_diag : w_min + LW'(1);

        n_d = r_d;
        if (i_ld.clr) begin
            n_d = IDX;
        end else if (!i_stall && i_tok.valid) begin
            if (i_tok.last) begin
                n_d = IDX;
            end else if (i_tok.proc) begin
                n_d = w_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d   <= IDX;
            r_tok <= '0;
        end else begin
            r_d <= n_d;
            if (!i_stall) begin
                r_tok <= i_tok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.we && i_ld_idx == IDX_M1) begin
            r_q <= i_ld.ch;
        end
        if (!i_stall) begin
            r_up   <= w_v;
            r_diag <= r_d;
            r_row  <= (i_qlen == IDX) ? w_v : i_row;
        end
    end

    assign o_tok  = r_tok;
    assign o_up   = r_up;
    assign o_diag = r_diag;
    assign o_row  = r_row;

endmodule

FILE: sv/ase_tail.sv
// Result stage: running minimum of the last query row and the output register.
module ase_tail #(
    parameter int QUERY_MAX = ase_pkg::ASE_QUERY_MAX,
    parameter int TEXT_MAX  = ase_pkg::ASE_TEXT_MAX,
    localparam int LW       = $clog2(QUERY_MAX + 1),
    localparam int CW       = $clog2(TEXT_MAX + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clr,
    input  ase_pkg::t_tok              i_tok,
    input  logic [LW-1:0]              i_row,
    input  logic [LW-1:0]              i_qlen,
    input  logic [ase_pkg::MAXD_W-1:0] i_max_dist,
    input  logic                       i_out_ready,
    output logic                       o_stall,
    output logic                       o_out_valid,
    output logic [ase_pkg::DIST_W-1:0] o_distance,
    output logic                       o_found
);
    import ase_pkg::*;

    localparam int XW0 = (CW > LW) ? CW : LW;
    localparam int XW1 = (XW0 > MAXD_W) ? XW0 : MAXD_W;
    localparam int XW  = (XW1 > DIST_W) ? XW1 : DIST_W;

    logic [CW-1:0]     r_cnt, n_cnt;
    logic [LW-1:0]     r_best, n_best;
    logic              r_none, n_none;
    logic              r_out_valid, n_out_valid;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic              r_found, n_found;
    logic [XW-1:0]     w_dist;
    logic              w_ok;

    assign o_stall = r_out_valid && !i_out_ready;

    always_comb begin
        n_cnt       = r_cnt;
        n_best      = r_best;
        n_none      = r_none;
        n_out_valid = r_out_valid && !i_out_ready;
        n_dist      = r_dist;
        n_found     = r_found;
        w_dist      = '0;
        w_ok        = 1'b0;

        if (i_clr) begin
            n_cnt  = '0;
            n_none = 1'b1;
        end else if (!o_stall && i_tok.valid) begin
            if (i_tok.proc) begin
                n_cnt = r_cnt + CW'(1);
                if (i_qlen != '0 && (r_none || i_row < r_best)) begin
                    n_best = i_row;
                    n_none = 1'b0;
                end
            end
            if (i_tok.last) begin
                if (i_qlen == '0) begin
                    w_dist = XW'(n_cnt);
                    w_ok   = 1'b1;
                end else begin
                    w_dist = XW'(n_best);
                    w_ok   = !n_none;
                end
                w_ok        = w_ok && (w_dist <= XW'(i_max_dist));
                n_out_valid = 1'b1;
                n_found     = w_ok;
                n_dist      = w_ok ? w_dist[DIST_W-1:0] : '0;
                n_cnt       = '0;
                n_none      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_none      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_none      <= n_none;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best  <= n_best;
        r_dist  <= n_dist;
        r_found <= n_found;
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_dist;
    assign o_found     = r_found;

endmodule

FILE: sv/approx_substring_edit_distance.sv
// Approximate substring matcher, top level: input stage, cell row, result stage.
// A final text character passes the input register, every cell of the row and the
//   result register before its result is shown; a stuck result holds it back.
// Throughput: one character per cycle unless a stuck result stalls the row; a query
//   character after text waits until the cell row has drained.
// Reset (i_rst_n low, synchronous): empty query, entry i = i, no result, threshold 2.
module approx_substring_edit_distance #(
    parameter int QUERY_MAX = ase_pkg::ASE_QUERY_MAX,
    parameter int TEXT_MAX  = ase_pkg::ASE_TEXT_MAX
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ase_pkg::MAXD_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_mode,
    input  logic [ase_pkg::CH_W-1:0]   i_ch,
    input  logic                       i_last_char,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [ase_pkg::DIST_W-1:0] o_distance,
    output logic                       o_found
);
    import ase_pkg::*;

    localparam int LW = $clog2(QUERY_MAX + 1);
    localparam int CW = $clog2(TEXT_MAX + 1);

    // Each cell k holds query character k and column row k. A text character
    // travels down the row one cell per cycle while not stalled, carrying the
    // freshly computed row value (up) and the previous one (diag) to its neighbor,
    // plus the value of row query_length once it has passed that cell.

    logic [MAXD_W-1:0] r_max_dist;
    logic [LW-1:0]     r_qlen, n_qlen;
    logic              r_text_phase, n_text_phase;
    logic [CW-1:0]     r_cnt, n_cnt;
    t_tok              r_tok0, n_tok0;

    t_tok          w_tok  [0:QUERY_MAX];
    logic [LW-1:0] w_up   [0:QUERY_MAX];
    logic [LW-1:0] w_diag [0:QUERY_MAX];
    logic [LW-1:0] w_row  [0:QUERY_MAX];

    t_ld           w_ld;
    logic [LW-1:0] w_ld_idx;
    logic          w_stall;
    logic          w_busy;
    logic          w_acc;
    logic          w_proc;

    // Hold new query characters until every transaction in flight has left
    // the cell row; text characters flow freely unless the result is stuck.
    always_comb begin
        w_busy = 1'b0;
        for (int k = 0; k <= QUERY_MAX; k++) begin
            w_busy = w_busy | w_tok[k].valid;
        end
    end

    assign o_in_ready = !w_stall && (i_mode == MODE_TEXT || !w_busy);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_proc     = r_cnt < CW'(TEXT_MAX);

    always_comb begin
        n_qlen       = r_qlen;
        n_text_phase = r_text_phase;
        n_cnt        = r_cnt;
        n_tok0       = r_tok0;
        w_ld.we      = 1'b0;
        w_ld.clr     = 1'b0;
        w_ld.ch      = fold_case(i_ch);
        w_ld_idx     = r_text_phase ? '0 : r_qlen;

        if (!w_stall) begin
            n_tok0.valid = w_acc && i_mode == MODE_TEXT;
            n_tok0.proc  = w_proc;
            n_tok0.last  = i_last_char;
            n_tok0.ch    = fold_case(i_ch);
        end

        if (w_acc) begin
            unique case (i_mode)
                MODE_QUERY: begin
                    if (r_text_phase) begin
                        // drop the old query and restart the search
                        w_ld.clr     = 1'b1;
                        w_ld.we      = 1'b1;
                        n_qlen       = LW'(1);
                        n_text_phase = 1'b0;
                        n_cnt        = '0;
                    end else if (r_qlen < LW'(QUERY_MAX)) begin
                        w_ld.we = 1'b1;
                        n_qlen  = r_qlen + LW'(1);
                    end
                end
                MODE_TEXT: begin
                    n_text_phase = 1'b1;
                    if (i_last_char) begin
                        n_cnt = '0;
                    end else if (w_proc) begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist   <= MAXD_RESET;
            r_qlen       <= '0;
            r_text_phase <= 1'b0;
            r_cnt        <= '0;
            r_tok0       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max_dist <= i_cfg_wdata;
            end
            r_qlen       <= n_qlen;
            r_text_phase <= n_text_phase;
            r_cnt        <= n_cnt;
            r_tok0       <= n_tok0;
        end
    end

    // Row zero is always 0: a match may begin at any text position.
    assign w_tok[0]  = r_tok0;
    assign w_up[0]   = '0;
    assign w_diag[0] = '0;
    assign w_row[0]  = '0;

    for (genvar k = 1; k <= QUERY_MAX; k++) begin : g_cell
        ase_cell #(
            .QUERY_MAX (QUERY_MAX),
            .INDEX     (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_stall  (w_stall),
            .i_ld     (w_ld),
            .i_ld_idx (w_ld_idx),
            .i_qlen   (r_qlen),
            .i_tok    (w_tok[k-1]),
            .i_up     (w_up[k-1]),
            .i_diag   (w_diag[k-1]),
            .i_row    (w_row[k-1]),
            .o_tok    (w_tok[k]),
            .o_up     (w_up[k]),
            .o_diag   (w_diag[k]),
            .o_row    (w_row[k])
        );
    end

    ase_tail #(
        .QUERY_MAX (QUERY_MAX),
        .TEXT_MAX  (TEXT_MAX)
    ) u_tail (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr       (w_ld.clr),
        .i_tok       (w_tok[QUERY_MAX]),
        .i_row       (w_row[QUERY_MAX]),
        .i_qlen      (r_qlen),
        .i_max_dist  (r_max_dist),
        .i_out_ready (i_out_ready),
        .o_stall     (w_stall),
        .o_out_valid (o_out_valid),
        .o_distance  (o_distance),
        .o_found     (o_found)
    );

endmodule

FILE: sv/ase_checker.sv
// Port-level checks on the approximate substring matcher, bound to the top level.
module ase_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [ase_pkg::DIST_W-1:0] o_distance,
    input logic                       o_found
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_distance) && $stable(o_found))
        else $error("result changed while stalled");

    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_distance == '0)
        else $error("no-match result carries a nonzero distance");

    // a stuck result freezes the cell row, so no input may enter
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while result stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind approx_substring_edit_distance ase_checker u_ase_checker (.*);

FILE: dv/approx_substring_edit_distance_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the approximate substring matcher: stimulus table, random rounds, back-pressure.
module approx_substring_edit_distance_tb;
    import ase_pkg::*;

    localparam int QMAX           = ASE_QUERY_MAX;
    localparam int TMAX           = ASE_TEXT_MAX;
    localparam int PIPE_TAIL      = QMAX + 16;   // wavefront crosses every cell, plus margin
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PHASE_ITEMS    = 95;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int NUM_DIRECTED   = 25;

    // one search result as the block reports it
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              found;
    } t_match_result;

    // one row of the stimulus table; when pinned is set the typed result is expected
    typedef struct packed {
        logic              mode;
        logic [CH_W-1:0]   ch;
        logic              last;
        logic              pinned;
        logic [DIST_W-1:0] distance;
        logic              found;
    } t_directed_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [MAXD_W-1:0] i_cfg_wdata;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_mode;
    logic [CH_W-1:0]   i_ch;
    logic              i_last_char;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [DIST_W-1:0] o_distance;
    logic              o_found;

    approx_substring_edit_distance i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_ch        (i_ch),
        .i_last_char (i_last_char),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_distance  (o_distance),
        .o_found     (o_found)
    );

    // 8 ns period
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Search predictor: query store, Levenshtein column, best distance.
    // ------------------------------------------------------------------
    logic [CH_W-1:0]   query_chars [0:QMAX-1];
    int                query_len;
    int                dist_col [0:QMAX];
    int                text_len;
    int                best_dist;
    bit                in_text;
    logic [MAXD_W-1:0] match_limit;

    t_match_result     expected_matches [$];
    t_match_result     head_match;

    int                mismatch_count;
    int                sent_items;
    int                cycle_count;
    int                tx_idle_pct;
    int                rx_idle_pct;
    bit                rx_hold_req;

    t_directed_row     directed_rows [0:NUM_DIRECTED-1];

    function automatic logic [CH_W-1:0] fold_letter(input logic [CH_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    // restart the column so a match may begin anywhere in the next text
    function automatic void clear_search();
        for (int i = 0; i <= QMAX; i++) begin
            dist_col[i] = i;
        end
        text_len  = 0;
        best_dist = 32'hFFFF;
    endfunction

    // advance the predictor by one accepted character; flag a result when one is due
    task automatic search_step(input logic m, input logic [CH_W-1:0] c, input logic lst,
                               output bit has_result, output t_match_result res);
        int              diag;
        int              prev;
        int              v;
        int              d;
        logic [CH_W-1:0] t;
        has_result = 1'b0;
        res        = '0;
        if (m == MODE_QUERY) begin
            // a query character after text starts a new query and drops the partial text
            if (in_text) begin
                query_len = 0;
                in_text   = 1'b0;
                clear_search();
            end
            if (query_len < QMAX) begin
                query_chars[query_len] = c;
                query_len++;
            end
        end else begin
            in_text = 1'b1;
            // characters past the text capacity are neither counted nor searched
            if (text_len < TMAX) begin
                text_len++;
                t           = fold_letter(c);
                diag        = dist_col[0];
                dist_col[0] = 0;
                for (int i = 1; i <= query_len; i++) begin
                    prev = dist_col[i];
                    if (fold_letter(query_chars[i-1]) == t) begin
                        v = diag;
                    end else begin
                        v = prev;
                        if (dist_col[i-1] < v) v = dist_col[i-1];
                        if (diag < v) v = diag;
                        v = v + 1;
                    end
                    diag        = prev;
                    dist_col[i] = v;
                end
                if (query_len > 0 && dist_col[query_len] < best_dist) begin
                    best_dist = dist_col[query_len];
                end
            end
            if (lst) begin
                // empty query: the text length itself is the distance
                d          = (query_len == 0) ? text_len : best_dist;
                res.found  = (d <= match_limit);
                res.distance = res.found ? d[DIST_W-1:0] : '0;
                has_result = 1'b1;
                clear_search();
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Input side. Drive at the falling edge, take the transaction at the
    // rising edge where valid and ready are both high.
    // ------------------------------------------------------------------
    task automatic drive_char(input logic m, input logic [CH_W-1:0] c, input logic lst,
                              input bit use_pinned, input t_match_result pinned_res);
        bit            has_result;
        t_match_result res;
        // idle at random before offering; valid drops only while nothing is offered
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= m;
        i_ch        <= c;
        i_last_char <= lst;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        search_step(m, c, lst, has_result, res);
        if (has_result) begin
            expected_matches.push_back(use_pinned ? pinned_res : res);
        end
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic send_char(input logic m, input logic [CH_W-1:0] c, input logic lst);
        drive_char(m, c, lst, 1'b0, '0);
    endtask

    // hold the input until every expected result is out and the cell row is empty
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge i_clk);
        repeat (PIPE_TAIL) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_match_limit(input logic [MAXD_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        match_limit = value;
    endtask

    // mostly a small letter alphabet so texts match, then case-fold edges, then any byte
    function automatic logic [CH_W-1:0] rand_text_byte();
        int              r;
        logic [CH_W-1:0] b;
        r = $urandom_range(99);
        if (r < 70) begin
            b = 8'h61 + 8'($urandom_range(3));
            if ($urandom_range(1) != 0) b = b ^ 8'h20;
        end else if (r < 85) begin
            case ($urandom_range(7))
                0: b = 8'h40;   // just below 'A'
                1: b = 8'h5B;   // just above 'Z'
                2: b = 8'h60;   // just below 'a'
                3: b = 8'h7B;   // just above 'z'
                4: b = 8'h00;
                5: b = 8'hFF;
                6: b = 8'h5A;
                default: b = 8'h7A;
            endcase
        end else begin
            b = 8'($urandom_range(255));
        end
        return b;
    endfunction

    function automatic logic [CH_W-1:0] vary_case(input logic [CH_W-1:0] c);
        if (fold_letter(c) >= 8'h61 && fold_letter(c) <= 8'h7A && $urandom_range(1) != 0) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    // Load a query, then search a few texts built from it with random edits.
    // Now and then leave a text without its final mark so the next query discards it.
    task automatic run_search_round();
        int              r;
        int              qlen;
        int              n_texts;
        bit              abandon;
        logic [CH_W-1:0] qbuf [$];
        logic [CH_W-1:0] tbuf [$];
        r = $urandom_range(99);
        if (r < 5) begin
            qlen = $urandom_range(QMAX - 4, QMAX + 6);   // reaches past the query capacity
        end else if (r < 15) begin
            qlen = $urandom_range(9, 40);
        end else begin
            qlen = $urandom_range(1, 8);
        end
        for (int k = 0; k < qlen; k++) begin
            qbuf.push_back(rand_text_byte());
            // the final mark is meaningless on a query character: toggle it anyway
            send_char(MODE_QUERY, qbuf[k], 1'($urandom_range(1)));
        end
        n_texts = $urandom_range(1, 4);
        for (int t = 0; t < n_texts; t++) begin
            tbuf.delete();
            repeat ($urandom_range(0, 4)) tbuf.push_back(rand_text_byte());
            foreach (qbuf[k]) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    // deletion: skip this query character
                end else if (r < 16) begin
                    tbuf.push_back(rand_text_byte());
                end else if (r < 24) begin
                    tbuf.push_back(rand_text_byte());
                    tbuf.push_back(vary_case(qbuf[k]));
                end else begin
                    tbuf.push_back(vary_case(qbuf[k]));
                end
            end
            repeat ($urandom_range(0, 4)) tbuf.push_back(rand_text_byte());
            if (tbuf.size() == 0) tbuf.push_back(rand_text_byte());
            abandon = ($urandom_range(99) < 8);
            foreach (tbuf[k]) begin
                send_char(MODE_TEXT, tbuf[k], (k == tbuf.size() - 1) && !abandon);
            end
            if (abandon) break;
        end
    endtask

    // broken traffic: any mode, any byte, any mark
    task automatic send_noise();
        repeat ($urandom_range(1, 6)) begin
            send_char(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    // ------------------------------------------------------------------
    // Output side. Ready changes at the falling edge; a long hold-off is
    // counted here, in its own process, when the stimulus asks for one.
    // ------------------------------------------------------------------
    always begin
        @(negedge i_clk);
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            i_out_ready <= 1'b0;
            repeat (RX_HOLD_CYCLES - 1) @(negedge i_clk);
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // compare every result transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_matches.size() == 0) begin
                report_mismatch($sformatf("result with none expected: distance %0d found %0b",
                                          o_distance, o_found));
            end else begin
                head_match = expected_matches.pop_front();
                if (o_distance !== head_match.distance) begin
                    report_mismatch($sformatf("distance %0d, expected %0d",
                                              o_distance, head_match.distance));
                end
                if (o_found !== head_match.found) begin
                    report_mismatch($sformatf("found %0b, expected %0b",
                                              o_found, head_match.found));
                end
            end
        end
    end

    // end the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_mode         = MODE_QUERY;
        i_ch           = '0;
        i_last_char    = 1'b0;
        i_out_ready    = 1'b0;
        mismatch_count = 0;
        sent_items     = 0;
        cycle_count    = 0;
        tx_idle_pct    = 7;
        rx_idle_pct    = 64;
        rx_hold_req    = 1'b0;
        query_len      = 0;
        in_text        = 1'b0;
        match_limit    = MAXD_RESET;
        clear_search();

        // Table at the reset threshold of 2. Empty query first, then case folding,
        // the bytes around the letter ranges, a discarded partial text.
        directed_rows = '{
            '{MODE_TEXT,  "a",   1'b1, 1'b1, 13'd1, 1'b1},  // empty query, length within limit
            '{MODE_TEXT,  "b",   1'b0, 1'b0, 13'd0, 1'b0},
            '{MODE_TEXT,  "c",   1'b0, 1'b0, 13'd0, 1'b0},
            '{MODE_TEXT,  "d",   1'b1, 1'b1, 13'd0, 1'b0},  // empty query, length above limit
            '{MODE_QUERY, "A",   1'b1, 1'b0, 13'd0, 1'b0},  // mark ignored on a query char
            '{MODE_QUERY, "b",   1'b0, 1'b0, 13'd0, 1'b0},
            '{MODE_TEXT,  "a",   1'b0, 1'b0, 13'd0, 1'b0},
            '{MODE_TEXT,  "B",   1'b1, 1'b1, 13'd0, 1'b1},  // exact match across case
            '{MODE_TEXT,  8'hFF, 1'b1, 1'b0, 13'd0, 1'b0},  // same query, fresh column
            '{MODE_QUERY, 8'h00, 1'b0, 1'b0, 13'd0, 1'b0},  // new query after text
            '{MODE_QUERY, 8'h40, 1'b0, 1'b0, 13'd0, 1'b0},
            '{MODE_QUERY, 8'h5B, 1'b0, 1'b0, 13'd0, 1'b0},
            '{MODE_QUERY, "z",   1'b0, 1'b0, 13'd0, 1'b0},
            '{MODE_TEXT,  8'h00, 1'b0, 1'b0, 13'd0, 1'b0},
            '{MODE_TEXT,  8'h40, 1'b0, 1'b0, 13'd0, 1'b0},
            '{MODE_TEXT,  8'h5B, 1'b0, 1'b0, 13'd0, 1'b0},
            '{MODE_TEXT,  "Z",   1'b1, 1'b1, 13'd0, 1'b1},
            '{MODE_TEXT,  "x",   1'b1, 1'b1, 13'd0, 1'b0},  // four edits, over the limit
            '{MODE_TEXT,  8'h00, 1'b0, 1'b0, 13'd0, 1'b0},
            '{MODE_TEXT,  8'h60, 1'b0, 1'b0, 13'd0, 1'b0},  // not the fold of 0x40
            '{MODE_TEXT,  8'h7B, 1'b0, 1'b0, 13'd0, 1'b0},  // not the fold of 0x5B
            '{MODE_TEXT,  "z",   1'b1, 1'b0, 13'd0, 1'b0},
            '{MODE_TEXT,  "q",   1'b0, 1'b0, 13'd0, 1'b0},  // partial text, then dropped
            '{MODE_QUERY, "q",   1'b0, 1'b0, 13'd0, 1'b0},
            '{MODE_TEXT,  "Q",   1'b1, 1'b1, 13'd0, 1'b1}
        };

        // hold reset, then release it at a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            drive_char(directed_rows[r].mode, directed_rows[r].ch, directed_rows[r].last,
                       directed_rows[r].pinned,
                       '{distance: directed_rows[r].distance, found: directed_rows[r].found});
        end

        // Random rounds: receiver idles first, then the sender, then neither.
        for (int ph = 0; ph < 6; ph++) begin
            int phase_start;
            drain_results();
            case (ph)
                0:       write_match_limit(7'd0);
                1:       write_match_limit(7'd64);
                2:       write_match_limit(7'($urandom_range(1, 6)));
                3:       write_match_limit(7'd1);
                4:       write_match_limit(7'd3);
                default: write_match_limit(7'($urandom_range(0, 64)));
            endcase
            tx_idle_pct = (ph < 2) ? 7  : (ph < 4) ? 64 : 0;
            rx_idle_pct = (ph < 2) ? 64 : (ph < 4) ? 7  : 0;
            phase_start = sent_items;
            while (sent_items - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(99) < 85) begin
                    run_search_round();
                end else begin
                    send_noise();
                end
            end
        end

        // Back-pressure: block the receiver for a long stretch while short texts keep
        // coming, so the result path fills and the input stalls.
        drain_results();
        write_match_limit(7'd2);
        @(posedge i_clk);
        rx_hold_req = 1'b1;
        @(negedge i_clk);
        send_char(MODE_QUERY, "a", 1'b0);
        for (int k = 0; k < 150; k++) begin
            send_char(MODE_TEXT, rand_text_byte(), 1'b1);
        end

        drain_results();
        if (expected_matches.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_matches.size()));
        end
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
